### sv/idc_pkg.sv
// Shared constants, status codes and calendar tables for the day count block.
`default_nettype none

package idc_pkg;

  // Field widths of the date pair and the result.
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned COUNT_W  = 22;
  localparam int unsigned STATUS_W = 2;

  // Default upper bound of an accepted year.
  localparam int unsigned MAX_YEAR_DEFAULT = 9999;

  // A day number of any 14-bit year fits in 23 bits.
  localparam int unsigned DAYNUM_W = 23;

  // Width of the year bound compare, wide enough for any 16-bit bound.
  localparam int unsigned YBOUND_W = 17;

  // Division by 100 through a reciprocal multiply, exact below 2**14.
  localparam int unsigned DIV100_SHIFT = 20;
  localparam int unsigned DIV100_MUL   = 10486;
  localparam int unsigned DIV100_PW    = YEAR_W + 14;
  localparam int unsigned QUOT100_W    = 8;
  localparam int unsigned CENTURY      = 100;

  localparam int unsigned DAYS_PER_YEAR = 365;

  // Width of the small terms of a day number: leap corrections,
  // days before the month and the day itself.
  localparam int unsigned ADJ_W   = YEAR_W - 2;
  localparam int unsigned SMALL_W = ADJ_W + 1;
  localparam int unsigned DBM_W   = 9;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_DATE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REVERSED = 2'd2;

  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // Days in the months before the given one, common year.
  function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [DBM_W-1:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Length of the given month; February follows the leap flag.
  function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [DAY_W-1:0] r;
    case (m)
      4'd2:    r = leap ? 5'd29 : 5'd28;
      4'd4,
      4'd6,
      4'd9,
      4'd11:   r = 5'd30;
      4'd1,
      4'd3,
      4'd5,
      4'd7,
      4'd8,
      4'd10,
      4'd12:   r = 5'd31;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/idc_if.sv
// Valid/ready channel interfaces for date pair beats and day count beats.
`default_nettype none

interface idc_in_if;
  logic                            valid;
  logic                            ready;
  logic [idc_pkg::MONTH_W-1:0]     first_month;
  logic [idc_pkg::DAY_W-1:0]       first_day;
  logic [idc_pkg::YEAR_W-1:0]      first_year;
  logic [idc_pkg::MONTH_W-1:0]     second_month;
  logic [idc_pkg::DAY_W-1:0]       second_day;
  logic [idc_pkg::YEAR_W-1:0]      second_year;

  modport source (
    output valid, first_month, first_day, first_year,
           second_month, second_day, second_year,
    input  ready
  );
  modport sink (
    input  valid, first_month, first_day, first_year,
           second_month, second_day, second_year,
    output ready
  );
endinterface

interface idc_out_if;
  logic                            valid;
  logic                            ready;
  logic [idc_pkg::COUNT_W-1:0]     day_count;
  logic [idc_pkg::STATUS_W-1:0]    status;

  modport source (
    output valid, day_count, status,
    input  ready
  );
  modport sink (
    input  valid, day_count, status,
    output ready
  );
endinterface

`default_nettype wire

### sv/inclusive_day_count_between_dates.sv
// Top level: pipelined inclusive day count between two Gregorian dates.
//
// Each input beat carries two dates (month, day, year); each output beat gives
// the number of days from the first date to the second, both ends counted, with
// status 0. A month, day or year out of range in either date gives status 1, a
// second date before the first gives status 2, and the count is zero in both
// cases. The block takes one date pair per cycle unless the output stalls, and
// each result passes five register stages: reciprocal multiplies for the
// century division, leap and correction terms, month table and validity, day
// number sum, and compare with the output register. A stall on the output
// backs up stage by stage, and empty stages still take data.
// Years from 1 to MAX_YEAR are accepted.
`default_nettype none

module inclusive_day_count_between_dates #(
  parameter int unsigned MAX_YEAR = idc_pkg::MAX_YEAR_DEFAULT
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  idc_in_if.sink     in_i,
  idc_out_if.source  out_o
);

  localparam int unsigned MW = idc_pkg::MONTH_W;
  localparam int unsigned DW = idc_pkg::DAY_W;
  localparam int unsigned YW = idc_pkg::YEAR_W;
  localparam int unsigned NW = idc_pkg::DAYNUM_W;
  localparam int unsigned PW = idc_pkg::DIV100_PW;
  localparam int unsigned QW = idc_pkg::QUOT100_W;
  localparam int unsigned AW = idc_pkg::ADJ_W;
  localparam int unsigned SW = idc_pkg::SMALL_W;

  // Stage valid bits and advance enables.
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
  logic s1_en, s2_en, s3_en, s4_en, out_en;

  assign out_en = !out_v_q || out_o.ready;
  assign s4_en  = !s4_v_q  || out_en;
  assign s3_en  = !s3_v_q  || s4_en;
  assign s2_en  = !s2_v_q  || s3_en;
  assign s1_en  = !s1_v_q  || s2_en;

  assign in_i.ready = s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_en)  s1_v_q  <= in_i.valid;
      if (s2_en)  s2_v_q  <= s1_v_q;
      if (s3_en)  s3_v_q  <= s2_v_q;
      if (s4_en)  s4_v_q  <= s3_v_q;
      if (out_en) out_v_q <= s4_v_q;
    end
  end

  // Per-date inputs, lane 0 is the first date and lane 1 the second.
  logic [1:0][MW-1:0] in_month;
  logic [1:0][DW-1:0] in_day;
  logic [1:0][YW-1:0] in_year;

  assign in_month = {in_i.second_month, in_i.first_month};
  assign in_day   = {in_i.second_day,   in_i.first_day};
  assign in_year  = {in_i.second_year,  in_i.first_year};

  // Date validity and day number of each lane at stage four.
  logic [1:0]         s4_ok_q;
  logic [1:0][NW-1:0] s4_num_q;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [MW-1:0] s1_month_q, s2_month_q;
    logic [DW-1:0] s1_day_q,   s2_day_q;
    logic [YW-1:0] s1_year_q,  s1_py_q;
    logic          s1_yok_q,   s2_yok_q;
    logic [PW-1:0] s1_prod_y_q, s1_prod_py_q;
    logic          s2_leap_q;
    logic [NW-1:0] s2_py365_q, s3_py365_q;
    logic [AW-1:0] s2_adj_q;
    logic          s3_ok_q;
    logic [SW-1:0] s3_small_q;

    // Stage one: year bounds and reciprocal multiplies for division by 100.
    logic [YW-1:0] py_d;
    logic          yok_d;

    assign py_d  = in_year[l] - YW'(1);
    assign yok_d = (in_year[l] != '0) &&
                   ({{(idc_pkg::YBOUND_W - YW){1'b0}}, in_year[l]}
                    <= idc_pkg::YBOUND_W'(MAX_YEAR));

    always_ff @(posedge clk_i) begin
      if (s1_en) begin
        s1_month_q   <= in_month[l];
        s1_day_q     <= in_day[l];
        s1_year_q    <= in_year[l];
        s1_py_q      <= py_d;
        s1_yok_q     <= yok_d;
        s1_prod_y_q  <= PW'(in_year[l]) * PW'(idc_pkg::DIV100_MUL);
        s1_prod_py_q <= PW'(py_d) * PW'(idc_pkg::DIV100_MUL);
      end
    end

    // Stage two: leap flag, whole years in days and the leap day correction.
    logic [QW-1:0] q_y, q_py;
    logic          div100, leap_d;
    logic [AW-1:0] adj_d;

    assign q_y    = s1_prod_y_q[idc_pkg::DIV100_SHIFT +: QW];
    assign q_py   = s1_prod_py_q[idc_pkg::DIV100_SHIFT +: QW];
    assign div100 = (s1_year_q == YW'(YW'(q_y) * YW'(idc_pkg::CENTURY)));
    assign leap_d = div100 ? (q_y[1:0] == 2'b00) : (s1_year_q[1:0] == 2'b00);
    assign adj_d  = s1_py_q[YW-1:2] - AW'(q_py) + AW'(q_py[QW-1:2]);

    always_ff @(posedge clk_i) begin
      if (s2_en) begin
        s2_month_q <= s1_month_q;
        s2_day_q   <= s1_day_q;
        s2_yok_q   <= s1_yok_q;
        s2_leap_q  <= leap_d;
        s2_py365_q <= NW'(s1_py_q) * NW'(idc_pkg::DAYS_PER_YEAR);
        s2_adj_q   <= adj_d;
      end
    end

    // Stage three: month table, day range check and the small terms.
    logic          mok_d, dok_d, leapfix;
    logic [DW-1:0] len_d;

    assign mok_d   = (s2_month_q != '0) && (s2_month_q <= idc_pkg::MONTH_DEC);
    assign len_d   = idc_pkg::month_length(s2_month_q, s2_leap_q);
    assign dok_d   = (s2_day_q != '0) && (s2_day_q <= len_d);
    assign leapfix = s2_leap_q && (s2_month_q > idc_pkg::MONTH_FEB);

    always_ff @(posedge clk_i) begin
      if (s3_en) begin
        s3_ok_q    <= mok_d && dok_d && s2_yok_q;
        s3_py365_q <= s2_py365_q;
        s3_small_q <= SW'(s2_adj_q) + SW'(idc_pkg::days_before_month(s2_month_q))
                      + SW'(s2_day_q) + SW'(leapfix);
      end
    end

    // Stage four: full day number.
    always_ff @(posedge clk_i) begin
      if (s4_en) begin
        s4_ok_q[l]  <= s3_ok_q;
        s4_num_q[l] <= s3_py365_q + NW'(s3_small_q);
      end
    end
  end

  // Output stage: order check, inclusive difference and saturation.
  logic [NW:0]                   cnt_d;
  logic [idc_pkg::COUNT_W-1:0]   count_d;
  logic [idc_pkg::STATUS_W-1:0]  status_d;

  assign cnt_d = {1'b0, s4_num_q[1]} - {1'b0, s4_num_q[0]} + (NW+1)'(1);

  always_comb begin
    if (!(s4_ok_q[0] && s4_ok_q[1])) begin
      status_d = idc_pkg::STATUS_BAD_DATE;
      count_d  = '0;
    end else if (s4_num_q[1] < s4_num_q[0]) begin
      status_d = idc_pkg::STATUS_REVERSED;
      count_d  = '0;
    end else begin
      status_d = idc_pkg::STATUS_OK;
      if (cnt_d[NW:idc_pkg::COUNT_W] != '0) begin
        count_d = idc_pkg::COUNT_MAX;
      end else begin
        count_d = cnt_d[idc_pkg::COUNT_W-1:0];
      end
    end
  end

  logic [idc_pkg::COUNT_W-1:0]  count_q;
  logic [idc_pkg::STATUS_W-1:0] status_q;

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      count_q  <= count_d;
      status_q <= status_d;
    end
  end

  assign out_o.valid     = out_v_q;
  assign out_o.day_count = count_q;
  assign out_o.status    = status_q;

endmodule

`default_nettype wire

### tb/inclusive_day_count_between_dates_tb.sv
// Testbench for the inclusive day count block: directed table, random date pairs, self-checking.
module inclusive_day_count_between_dates_tb;

  localparam int unsigned MONTH_W  = idc_pkg::MONTH_W;
  localparam int unsigned DAY_W    = idc_pkg::DAY_W;
  localparam int unsigned YEAR_W   = idc_pkg::YEAR_W;
  localparam int unsigned COUNT_W  = idc_pkg::COUNT_W;
  localparam int unsigned STATUS_W = idc_pkg::STATUS_W;

  localparam int unsigned TB_MAX_YEAR = idc_pkg::MAX_YEAR_DEFAULT;
  localparam int unsigned YEAR_FIELD_MAX = (1 << YEAR_W) - 1;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned ITEMS_PER_PHASE = 200;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [MONTH_W-1:0] first_month;
    logic [DAY_W-1:0]   first_day;
    logic [YEAR_W-1:0]  first_year;
    logic [MONTH_W-1:0] second_month;
    logic [DAY_W-1:0]   second_day;
    logic [YEAR_W-1:0]  second_year;
  } date_pair_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  day_count;
    logic [STATUS_W-1:0] status;
  } day_result_t;

  // One row of the directed table; typed rows carry their own answer.
  typedef struct packed {
    date_pair_t  pair;
    logic        typed;
    day_result_t result;
  } stim_row_t;

  localparam int unsigned NUM_DIRECTED = 22;
  localparam stim_row_t DIRECTED_ROWS[NUM_DIRECTED] = '{
    // Same first day of the calendar on both sides.
    '{'{1, 1, 1, 1, 1, 1}, 1'b1, '{1, idc_pkg::STATUS_OK}},
    // Widest span the default year bound allows.
    '{'{1, 1, 1, 12, 31, 9999}, 1'b1, '{3652059, idc_pkg::STATUS_OK}},
    // Months out of range.
    '{'{0, 1, 2000, 1, 1, 2001}, 1'b1, '{0, idc_pkg::STATUS_BAD_DATE}},
    '{'{13, 1, 2000, 1, 1, 2001}, 1'b1, '{0, idc_pkg::STATUS_BAD_DATE}},
    '{'{1, 1, 2000, 15, 1, 2001}, 1'b1, '{0, idc_pkg::STATUS_BAD_DATE}},
    // Days out of range.
    '{'{1, 0, 2000, 1, 1, 2001}, 1'b1, '{0, idc_pkg::STATUS_BAD_DATE}},
    '{'{1, 1, 2000, 4, 31, 2001}, 1'b1, '{0, idc_pkg::STATUS_BAD_DATE}},
    // Leap day in a year divisible by 400.
    '{'{2, 29, 2000, 3, 1, 2000}, 1'b0, '{0, idc_pkg::STATUS_OK}},
    // Leap day in a century year that is not a leap year.
    '{'{2, 29, 1900, 3, 1, 1900}, 1'b1, '{0, idc_pkg::STATUS_BAD_DATE}},
    '{'{2, 29, 2024, 2, 29, 2028}, 1'b0, '{0, idc_pkg::STATUS_OK}},
    '{'{2, 28, 2023, 2, 29, 2023}, 1'b1, '{0, idc_pkg::STATUS_BAD_DATE}},
    // Years out of range.
    '{'{1, 1, 0, 1, 1, 5}, 1'b1, '{0, idc_pkg::STATUS_BAD_DATE}},
    '{'{1, 1, 5, 1, 1, 10000}, 1'b1, '{0, idc_pkg::STATUS_BAD_DATE}},
    '{'{1, 1, 16383, 1, 1, 16383}, 1'b1, '{0, idc_pkg::STATUS_BAD_DATE}},
    // Second date one day before the first.
    '{'{1, 2, 2000, 1, 1, 2000}, 1'b1, '{0, idc_pkg::STATUS_REVERSED}},
    // Invalid and reversed together: the invalid date wins.
    '{'{12, 31, 9999, 13, 1, 1}, 1'b1, '{0, idc_pkg::STATUS_BAD_DATE}},
    '{'{12, 31, 9999, 12, 31, 9999}, 1'b1, '{1, idc_pkg::STATUS_OK}},
    '{'{2, 28, 2000, 3, 1, 2000}, 1'b0, '{0, idc_pkg::STATUS_OK}},
    '{'{1, 1, 2000, 12, 31, 2000}, 1'b0, '{0, idc_pkg::STATUS_OK}},
    '{'{1, 31, 2023, 12, 31, 2023}, 1'b0, '{0, idc_pkg::STATUS_OK}},
    '{'{12, 31, 1999, 1, 1, 2000}, 1'b0, '{0, idc_pkg::STATUS_OK}},
    // Every input bit set.
    '{'{15, 31, 16383, 15, 31, 16383}, 1'b1, '{0, idc_pkg::STATUS_BAD_DATE}}
  };

  logic clk;
  logic rst_n;

  idc_in_if  date_if ();
  idc_out_if count_if ();

  inclusive_day_count_between_dates #(
    .MAX_YEAR(TB_MAX_YEAR)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (date_if.sink),
    .out_o (count_if.source)
  );

  day_result_t expected_counts[$];
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;

  // Clock with a period of two time units.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit is_leap(input int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned days_in_month(input logic [MONTH_W-1:0] m, input bit leap);
    case (m)
      idc_pkg::MONTH_FEB:      return leap ? 29 : 28;
      4'd4, 4'd6, 4'd9, 4'd11: return 30;
      default:                 return 31;
    endcase
  endfunction

  // Day number of a date with 1 January of year 1 as day 1; returns 0 if the date is invalid.
  function automatic bit day_number(input logic [MONTH_W-1:0] m, input logic [DAY_W-1:0] d,
                                    input logic [YEAR_W-1:0] y, output int unsigned num);
    int unsigned py;
    int unsigned dbm;
    bit leap;
    num = 0;
    if (m < 1 || m > idc_pkg::MONTH_DEC) return 1'b0;
    if (y < 1 || y > TB_MAX_YEAR) return 1'b0;
    leap = is_leap(y);
    if (d < 1 || d > days_in_month(m, leap)) return 1'b0;
    dbm = 0;
    for (int k = 1; k < m; k++) dbm += days_in_month(MONTH_W'(k), leap);
    py = y - 1;
    num = py * 365 + py / 4 - py / 100 + py / 400 + dbm + d;
    return 1'b1;
  endfunction

  function automatic day_result_t predict_day_count(input date_pair_t p);
    int unsigned n1;
    int unsigned n2;
    int unsigned span;
    bit ok1;
    bit ok2;
    day_result_t r;
    ok1 = day_number(p.first_month, p.first_day, p.first_year, n1);
    ok2 = day_number(p.second_month, p.second_day, p.second_year, n2);
    r = '{0, idc_pkg::STATUS_OK};
    if (!ok1 || !ok2) begin
      r.status = idc_pkg::STATUS_BAD_DATE;
    end else if (n2 < n1) begin
      r.status = idc_pkg::STATUS_REVERSED;
    end else begin
      span = n2 - n1 + 1;
      r.day_count = (span > idc_pkg::COUNT_MAX) ? idc_pkg::COUNT_MAX : COUNT_W'(span);
    end
    return r;
  endfunction

  // Years weighted toward the ends of the range and the leap rule corners.
  function automatic logic [YEAR_W-1:0] pick_year();
    case ($urandom_range(9))
      0:       return YEAR_W'($urandom_range(1, 12));
      1:       return YEAR_W'(TB_MAX_YEAR - $urandom_range(0, 12));
      2:       return YEAR_W'(400 * $urandom_range(1, 24));
      3:       return YEAR_W'(100 * $urandom_range(1, 99));
      4:       return YEAR_W'(4 * $urandom_range(1, 2499));
      default: return YEAR_W'($urandom_range(1, TB_MAX_YEAR));
    endcase
  endfunction

  function automatic void valid_date(output logic [MONTH_W-1:0] m, output logic [DAY_W-1:0] d,
                                     input logic [YEAR_W-1:0] y);
    m = MONTH_W'($urandom_range(1, idc_pkg::MONTH_DEC));
    d = DAY_W'($urandom_range(1, days_in_month(m, is_leap(y))));
  endfunction

  // Break one field of a valid date.
  function automatic void corrupt_date(inout logic [MONTH_W-1:0] m, inout logic [DAY_W-1:0] d,
                                       inout logic [YEAR_W-1:0] y);
    int unsigned len;
    case ($urandom_range(5))
      0: m = '0;
      1: m = MONTH_W'($urandom_range(idc_pkg::MONTH_DEC + 1, (1 << MONTH_W) - 1));
      2: d = '0;
      3: begin
        len = days_in_month(m, is_leap(y));
        if (len < 31) begin
          d = DAY_W'($urandom_range(len + 1, 31));
        end else begin
          m = idc_pkg::MONTH_FEB;
          d = DAY_W'($urandom_range(30, 31));
        end
      end
      4: y = '0;
      default: y = YEAR_W'($urandom_range(TB_MAX_YEAR + 1, YEAR_FIELD_MAX));
    endcase
  endfunction

  // Mostly well-ordered valid pairs, then reversed pairs, broken dates and raw noise.
  function automatic date_pair_t random_pair();
    date_pair_t p;
    date_pair_t swapped;
    int unsigned n1;
    int unsigned n2;
    int unsigned yr;
    int unsigned kind;
    kind = $urandom_range(99);
    if (kind < 12) begin
      p.first_month  = MONTH_W'($urandom);
      p.first_day    = DAY_W'($urandom);
      p.first_year   = YEAR_W'($urandom);
      p.second_month = MONTH_W'($urandom);
      p.second_day   = DAY_W'($urandom);
      p.second_year  = YEAR_W'($urandom);
      return p;
    end
    p.first_year = pick_year();
    valid_date(p.first_month, p.first_day, p.first_year);
    if ($urandom_range(99) < 40) begin
      // Short span: same year or one of the next two.
      yr = p.first_year + $urandom_range(0, 2);
      p.second_year = YEAR_W'((yr > TB_MAX_YEAR) ? TB_MAX_YEAR : yr);
    end else begin
      p.second_year = pick_year();
    end
    valid_date(p.second_month, p.second_day, p.second_year);
    if ($urandom_range(99) < 5) begin
      p.second_month = p.first_month;
      p.second_day   = p.first_day;
      p.second_year  = p.first_year;
    end
    void'(day_number(p.first_month, p.first_day, p.first_year, n1));
    void'(day_number(p.second_month, p.second_day, p.second_year, n2));
    swapped = '{p.second_month, p.second_day, p.second_year,
                p.first_month, p.first_day, p.first_year};
    if (kind < 72) begin
      if (n2 < n1) p = swapped;
    end else if (kind < 86) begin
      if (n1 < n2) p = swapped;
    end else if ($urandom_range(1)) begin
      corrupt_date(p.first_month, p.first_day, p.first_year);
    end else begin
      corrupt_date(p.second_month, p.second_day, p.second_year);
    end
    return p;
  endfunction

  task automatic note_mismatch(input string what, input day_result_t want, input day_result_t got);
    if (mismatches < REPORT_LIMIT) begin
      $display("%s: expected count %0d status %0d, got count %0d status %0d",
               what, want.day_count, want.status, got.day_count, got.status);
    end
    mismatches++;
  endtask

  // Offer one date pair, with random idle cycles in front, and queue its answer once accepted.
  task automatic send_pair(input date_pair_t p, input day_result_t answer);
    while ($urandom_range(99) < snd_idle_pct) begin
      date_if.valid <= 1'b0;
      @(posedge clk);
    end
    date_if.valid        <= 1'b1;
    date_if.first_month  <= p.first_month;
    date_if.first_day    <= p.first_day;
    date_if.first_year   <= p.first_year;
    date_if.second_month <= p.second_month;
    date_if.second_day   <= p.second_day;
    date_if.second_year  <= p.second_year;
    @(posedge clk);
    while (!date_if.ready) @(posedge clk);
    expected_counts.push_back(answer);
  endtask

  // Hold the sender off until every queued answer has come back.
  task automatic wait_for_drain();
    date_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_counts.size() != 0) @(posedge clk);
  endtask

  // Result beats are compared with the oldest queued answer.
  always @(posedge clk) begin
    day_result_t got;
    day_result_t want;
    if (rst_n && count_if.valid && count_if.ready) begin
      got = '{count_if.day_count, count_if.status};
      if (expected_counts.size() == 0) begin
        note_mismatch("unexpected result beat", '0, got);
      end else begin
        want = expected_counts.pop_front();
        if (got.day_count !== want.day_count || got.status !== want.status) begin
          note_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  // Receiver stalls at random according to the current idle rate.
  initial begin
    count_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      count_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Watchdog on the whole run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("inclusive_day_count_between_dates test failed");
    $finish;
  end

  // Main stimulus: reset, directed table, then three random phases.
  initial begin
    day_result_t answer;
    mismatches    = 0;
    snd_idle_pct  = 18;
    rcv_idle_pct  = 48;
    rst_n         <= 1'b0;
    date_if.valid <= 1'b0;
    date_if.first_month  <= '0;
    date_if.first_day    <= '0;
    date_if.first_year   <= '0;
    date_if.second_month <= '0;
    date_if.second_day   <= '0;
    date_if.second_year  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      answer = DIRECTED_ROWS[i].typed ? DIRECTED_ROWS[i].result
                                      : predict_day_count(DIRECTED_ROWS[i].pair);
      send_pair(DIRECTED_ROWS[i].pair, answer);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          snd_idle_pct = 18;
          rcv_idle_pct = 48;
        end
        1: begin
          snd_idle_pct = 48;
          rcv_idle_pct = 18;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        date_pair_t p;
        if (k == ITEMS_PER_PHASE / 2) wait_for_drain();
        p = random_pair();
        send_pair(p, predict_day_count(p));
      end
    end

    date_if.valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_counts.size() == 0) begin
      $display("inclusive_day_count_between_dates test passed");
    end else begin
      $display("inclusive_day_count_between_dates test failed");
    end
    $finish;
  end

endmodule

### inclusive_day_count_between_dates.f
sv/idc_pkg.sv
sv/idc_if.sv
sv/inclusive_day_count_between_dates.sv
tb/inclusive_day_count_between_dates_tb.sv
